/* rtl/boolean_infix_expression_evaluator_assert.svh */
// Assertion macros shared by the evaluator RTL.
// Expects signals named clock and reset in the including module.
`ifndef BOOLEAN_INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define BOOLEAN_INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BIE_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BIE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bie_pkg.sv */
// Shared types, character codes and operator helpers of the boolean evaluator.
// No dependencies; used by bie_ram and boolean_infix_expression_evaluator.
package bie_pkg;

   // Default depth of both stacks.
   localparam int unsigned STACK_DEPTH_DEFAULT = 64;

   // Width of one operator stack entry.
   localparam int unsigned OP_W = 3;

   // Characters the evaluator recognizes (upper case).
   localparam logic [7:0] CH_T       = 8'h54;
   localparam logic [7:0] CH_F       = 8'h46;
   localparam logic [7:0] CH_N       = 8'h4e;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_X       = 8'h58;
   localparam logic [7:0] CH_O       = 8'h4f;
   localparam logic [7:0] CH_LPAR    = 8'h28;
   localparam logic [7:0] CH_RPAR    = 8'h29;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   // Operator codes as stored on the operator stack.
   typedef enum logic [OP_W-1:0] {
      OP_LPAR = 3'd0,
      OP_OR   = 3'd1,
      OP_XOR  = 3'd2,
      OP_AND  = 3'd3,
      OP_NOT  = 3'd4
   } op_type;

   // Input transaction payload.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic valid_res;
      logic value;
   } rsp_type;

   // Fold lower-case letters onto upper case.
   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         r = c - CASE_SHIFT;
      end
      return r;
   endfunction

   // Binding strength: not above and above xor and or; brackets lowest.
   function automatic logic [1:0] rank_of(input op_type op);
      logic [1:0] r;
      case (op)
         OP_OR, OP_XOR: r = 2'd1;
         OP_AND:        r = 2'd2;
         OP_NOT:        r = 2'd3;
         default:       r = 2'd0;
      endcase
      return r;
   endfunction

   // Binary logic unit: a is the top value, b the one below it.
   function automatic logic apply_binary(input op_type op, input logic a, input logic b);
      logic r;
      case (op)
         OP_AND:  r = a & b;
         OP_OR:   r = a | b;
         default: r = a ^ b;
      endcase
      return r;
   endfunction

endpackage

/* rtl/bie_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on bie_pkg for its default depth.
module bie_ram #(
   parameter int unsigned WIDTH  = 1,
   parameter int unsigned DEPTH  = bie_pkg::STACK_DEPTH_DEFAULT,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/boolean_infix_expression_evaluator.sv */
// Top level of the boolean infix expression evaluator (shunting-yard sequencer).
// Depends on bie_pkg, bie_ram and boolean_infix_expression_evaluator_assert.svh.
//
//   channel   ports                          moves
//   req       req_valid req_stall req_data   one expression character per transaction
//   rsp       rsp_valid rsp_stall rsp_data   one result per character marked last
//
// Constants, opening brackets, nots, skipped bytes and anything after an error need no pop loop.
// A binary operator pops the stacked operators that bind at least as tightly, and a closing
// bracket pops down to its opening bracket; a popped binary operator also reads the value
// stack, since the stack memories have registered reads.
// The last character adds a flush that pops every operator left; a stalled result holds the
// flush. Reset clears only the state, the counters and the flags, with no clearing pass.
`include "boolean_infix_expression_evaluator_assert.svh"

module boolean_infix_expression_evaluator #(
   parameter int unsigned STACK_DEPTH = bie_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bie_pkg::rsp_type rsp_data
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE_CNT   = CW'(1);
   localparam logic [CW-1:0] TWO_CNT   = CW'(2);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOP,
      S_OPRD,
      S_VALRD,
      S_NEXT
   } state_type;

   typedef enum logic [1:0] {
      M_BIN,
      M_CLOSE,
      M_FLUSH
   } mode_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   bie_pkg::op_type  pend_op_ff, pend_op_in;
   bie_pkg::op_type  apply_op_ff, apply_op_in;
   logic             last_ff, last_in;
   logic             err_ff, err_in;
   logic [CW-1:0]    op_count_ff, op_count_in;
   logic [CW-1:0]    val_count_ff, val_count_in;
   logic             val_top_ff, val_top_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bie_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             rsp_load;

   logic [CW-1:0] ocnt_m1, vcnt_m1, vcnt_m2;

   // Operator stack memory port.
   logic                    op_we, op_re;
   logic [AW-1:0]           op_waddr, op_raddr;
   logic [bie_pkg::OP_W-1:0] op_wdata, op_rdata;

   // Value stack memory port.
   logic          val_we, val_re;
   logic [AW-1:0] val_waddr, val_raddr;
   logic          val_wdata, val_rdata;

   // Requests from the sequencer to the push and apply paths.
   logic            vpush, vpush_bit;
   logic            opush;
   bie_pkg::op_type opush_code;
   logic            apply;
   bie_pkg::op_type apply_code;

   assign ocnt_m1 = op_count_ff - ONE_CNT;
   assign vcnt_m1 = val_count_ff - ONE_CNT;
   assign vcnt_m2 = val_count_ff - TWO_CNT;

   bie_ram #(
      .WIDTH (bie_pkg::OP_W),
      .DEPTH (STACK_DEPTH)
   ) u_op_ram (
      .clock   (clock),
      .wr_en   (op_we),
      .wr_addr (op_waddr),
      .wr_data (op_wdata),
      .rd_en   (op_re),
      .rd_addr (op_raddr),
      .rd_data (op_rdata)
   );

   bie_ram #(
      .WIDTH (1),
      .DEPTH (STACK_DEPTH)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_en   (val_re),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   // Sequencer: decode, pop loop, operator application and result.
   always_comb begin
      logic [7:0]      c;
      bie_pkg::op_type top_op;
      logic            res_ok;
      logic            alu_r;

      c      = bie_pkg::to_upper(req_data.ch);
      top_op = bie_pkg::op_type'(op_rdata);
      res_ok = !err_ff && (val_count_ff != '0);
      alu_r  = bie_pkg::apply_binary(apply_op_ff, val_top_ff, val_rdata);

      state_in     = state_ff;
      mode_in      = mode_ff;
      pend_op_in   = pend_op_ff;
      apply_op_in  = apply_op_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      op_count_in  = op_count_ff;
      val_count_in = val_count_ff;
      val_top_in   = val_top_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_load     = 1'b0;

      op_we     = 1'b0;
      op_waddr  = '0;
      op_wdata  = '0;
      op_re     = 1'b0;
      op_raddr  = '0;
      val_we    = 1'b0;
      val_waddr = '0;
      val_wdata = 1'b0;
      val_re    = 1'b0;
      val_raddr = '0;

      vpush      = 1'b0;
      vpush_bit  = 1'b0;
      opush      = 1'b0;
      opush_code = bie_pkg::OP_LPAR;
      apply      = 1'b0;
      apply_code = bie_pkg::OP_LPAR;

      // The output register drains independently of the sequencer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in  = req_data.last;
               state_in = S_NEXT;
               if (!err_ff) begin
                  unique case (c)
                     bie_pkg::CH_T: begin
                        vpush     = 1'b1;
                        vpush_bit = 1'b1;
                     end
                     bie_pkg::CH_F: begin
                        vpush     = 1'b1;
                        vpush_bit = 1'b0;
                     end
                     bie_pkg::CH_LPAR: begin
                        opush      = 1'b1;
                        opush_code = bie_pkg::OP_LPAR;
                     end
                     bie_pkg::CH_N: begin
                        opush      = 1'b1;
                        opush_code = bie_pkg::OP_NOT;
                     end
                     bie_pkg::CH_RPAR: begin
                        mode_in  = M_CLOSE;
                        state_in = S_LOOP;
                     end
                     bie_pkg::CH_A: begin
                        mode_in    = M_BIN;
                        pend_op_in = bie_pkg::OP_AND;
                        state_in   = S_LOOP;
                     end
                     bie_pkg::CH_X: begin
                        mode_in    = M_BIN;
                        pend_op_in = bie_pkg::OP_XOR;
                        state_in   = S_LOOP;
                     end
                     bie_pkg::CH_O: begin
                        mode_in    = M_BIN;
                        pend_op_in = bie_pkg::OP_OR;
                        state_in   = S_LOOP;
                     end
                     bie_pkg::CH_SPACE: begin
                        state_in = S_NEXT;
                     end
                     default: begin
                        state_in = S_NEXT;
                     end
                  endcase
               end
            end
         end

         S_LOOP: begin
            if (err_ff || op_count_ff == '0) begin
               if (mode_ff == M_FLUSH) begin
                  // Flush done: emit once the output register is free.
                  if (!(rsp_valid_ff && rsp_stall)) begin
                     rsp_load              = 1'b1;
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.valid_res = res_ok;
                     rsp_data_in.value     = res_ok & val_top_ff;
                     err_in                = 1'b0;
                     op_count_in           = '0;
                     val_count_in          = '0;
                     state_in              = S_IDLE;
                  end
               end else if (err_ff) begin
                  state_in = S_NEXT;
               end else if (mode_ff == M_CLOSE) begin
                  // Closing bracket without a matching opening one.
                  err_in   = 1'b1;
                  state_in = S_NEXT;
               end else begin
                  opush      = 1'b1;
                  opush_code = pend_op_ff;
                  state_in   = S_NEXT;
               end
            end else begin
               op_re    = 1'b1;
               op_raddr = ocnt_m1[AW-1:0];
               state_in = S_OPRD;
            end
         end

         S_OPRD: begin
            if (mode_ff == M_BIN) begin
               if (bie_pkg::rank_of(pend_op_ff) <= bie_pkg::rank_of(top_op)) begin
                  op_count_in = ocnt_m1;
                  apply       = 1'b1;
                  apply_code  = top_op;
                  state_in    = S_LOOP;
               end else begin
                  opush      = 1'b1;
                  opush_code = pend_op_ff;
                  state_in   = S_NEXT;
               end
            end else begin
               op_count_in = ocnt_m1;
               if (top_op == bie_pkg::OP_LPAR) begin
                  if (mode_ff == M_CLOSE) begin
                     state_in = S_NEXT;
                  end else begin
                     // Opening bracket left over at the flush.
                     err_in   = 1'b1;
                     state_in = S_LOOP;
                  end
               end else begin
                  apply      = 1'b1;
                  apply_code = top_op;
                  state_in   = S_LOOP;
               end
            end
         end

         S_VALRD: begin
            val_we       = 1'b1;
            val_waddr    = vcnt_m2[AW-1:0];
            val_wdata    = alu_r;
            val_top_in   = alu_r;
            val_count_in = vcnt_m1;
            state_in     = S_LOOP;
         end

         S_NEXT: begin
            if (last_ff) begin
               mode_in  = M_FLUSH;
               state_in = S_LOOP;
            end else begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Value push with overflow check.
      if (vpush) begin
         if (val_count_ff == DEPTH_CNT) begin
            err_in = 1'b1;
         end else begin
            val_we       = 1'b1;
            val_waddr    = val_count_ff[AW-1:0];
            val_wdata    = vpush_bit;
            val_top_in   = vpush_bit;
            val_count_in = val_count_ff + ONE_CNT;
         end
      end

      // Operator push with overflow check.
      if (opush) begin
         if (op_count_ff == DEPTH_CNT) begin
            err_in = 1'b1;
         end else begin
            op_we       = 1'b1;
            op_waddr    = op_count_ff[AW-1:0];
            op_wdata    = opush_code;
            op_count_in = op_count_ff + ONE_CNT;
         end
      end

      // Apply a popped operator: not in place, binary through a value read.
      if (apply) begin
         if (apply_code == bie_pkg::OP_NOT) begin
            if (val_count_ff == '0) begin
               err_in = 1'b1;
            end else begin
               val_we     = 1'b1;
               val_waddr  = vcnt_m1[AW-1:0];
               val_wdata  = !val_top_ff;
               val_top_in = !val_top_ff;
            end
         end else begin
            if (val_count_ff < TWO_CNT) begin
               err_in = 1'b1;
            end else begin
               val_re      = 1'b1;
               val_raddr   = vcnt_m2[AW-1:0];
               apply_op_in = apply_code;
               state_in    = S_VALRD;
            end
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_BIN;
         last_ff      <= 1'b0;
         err_ff       <= 1'b0;
         op_count_ff  <= '0;
         val_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         last_ff      <= last_in;
         err_ff       <= err_in;
         op_count_ff  <= op_count_in;
         val_count_ff <= val_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_op_ff  <= pend_op_in;
      apply_op_ff <= apply_op_in;
      val_top_ff  <= val_top_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer.
   `BIE_ASSERT_IMPLY(a_op_count_bound, 1'b1, op_count_ff <= DEPTH_CNT,
                     "operator count beyond depth")
   `BIE_ASSERT_IMPLY(a_val_count_bound, 1'b1, val_count_ff <= DEPTH_CNT,
                     "value count beyond depth")
   `BIE_ASSERT_IMPLY(a_invalid_is_zero, rsp_valid_ff && !rsp_data_ff.valid_res,
                     !rsp_data_ff.value, "invalid result carries a true value")
   `BIE_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != S_IDLE,
                    "accepted character did not start work")
   `BIE_ASSERT_NEXT(a_result_clears, rsp_load,
                    op_count_ff == '0 && val_count_ff == '0 && !err_ff && rsp_valid_ff,
                    "result did not clear the stacks")

endmodule

/* dv/expression_result_checker.sv */
// Checker for the boolean infix expression evaluator: watches both channels,
// predicts each result from the accepted characters and compares it.
// Depends on bie_pkg for the payload types, operator codes and character codes.
module expression_result_checker #(
   parameter int unsigned STACK_DEPTH = bie_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bie_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bie_pkg::rsp_type rsp_data,
   output int unsigned      mismatch_count,
   output int unsigned      pending_count
);

   // Shadow copy of the evaluator state.
   bie_pkg::op_type op_store[STACK_DEPTH];
   logic            val_store[STACK_DEPTH];
   int unsigned     op_depth;
   int unsigned     val_depth;
   logic            eval_error;

   // Results predicted but not yet seen on the result channel.
   bie_pkg::rsp_type expected_results[$];
   bie_pkg::rsp_type oldest;
   int unsigned      mismatches;

   // Binding strength of a stacked operator; an open bracket binds least.
   function automatic int unsigned binding_strength(bie_pkg::op_type op);
      case (op)
         bie_pkg::OP_OR, bie_pkg::OP_XOR: return 1;
         bie_pkg::OP_AND:                 return 2;
         bie_pkg::OP_NOT:                 return 3;
         default:                         return 0;
      endcase
   endfunction

   function automatic void push_value(logic v);
      if (val_depth >= STACK_DEPTH) begin
         eval_error = 1'b1;
      end else begin
         val_store[val_depth] = v;
         val_depth++;
      end
   endfunction

   function automatic void push_operator(bie_pkg::op_type op);
      if (op_depth >= STACK_DEPTH) begin
         eval_error = 1'b1;
      end else begin
         op_store[op_depth] = op;
         op_depth++;
      end
   endfunction

   // Apply one popped operator to the value stack.
   function automatic void apply_operator(bie_pkg::op_type op);
      logic top_v;
      logic below_v;
      logic r;
      if (op == bie_pkg::OP_NOT) begin
         if (val_depth < 1) begin
            eval_error = 1'b1;
         end else begin
            val_store[val_depth-1] = ~val_store[val_depth-1];
         end
      end else if (val_depth < 2) begin
         eval_error = 1'b1;
      end else begin
         top_v = val_store[val_depth-1];
         below_v = val_store[val_depth-2];
         val_depth -= 2;
         case (op)
            bie_pkg::OP_AND: r = top_v & below_v;
            bie_pkg::OP_OR:  r = top_v | below_v;
            default:         r = top_v ^ below_v;
         endcase
         push_value(r);
      end
   endfunction

   // Process one character in shunting-yard fashion.
   function automatic void take_char(logic [7:0] raw);
      logic [7:0]      c;
      bie_pkg::op_type op;
      logic            is_binary;
      logic            done;
      c = raw;
      if (c >= bie_pkg::CH_LOWER_A && c <= bie_pkg::CH_LOWER_Z) begin
         c = c - bie_pkg::CASE_SHIFT;
      end
      is_binary = 1'b0;
      op = bie_pkg::OP_LPAR;
      case (c)
         bie_pkg::CH_T:    push_value(1'b1);
         bie_pkg::CH_F:    push_value(1'b0);
         bie_pkg::CH_LPAR: push_operator(bie_pkg::OP_LPAR);
         bie_pkg::CH_N:    push_operator(bie_pkg::OP_NOT);
         bie_pkg::CH_RPAR: begin
            // Pop and apply until the matching open bracket.
            done = 1'b0;
            while (!done) begin
               if (op_depth == 0) begin
                  eval_error = 1'b1;
                  done = 1'b1;
               end else begin
                  op_depth--;
                  op = op_store[op_depth];
                  if (op == bie_pkg::OP_LPAR) begin
                     done = 1'b1;
                  end else begin
                     apply_operator(op);
                     if (eval_error) done = 1'b1;
                  end
               end
            end
         end
         bie_pkg::CH_A: begin
            op = bie_pkg::OP_AND;
            is_binary = 1'b1;
         end
         bie_pkg::CH_X: begin
            op = bie_pkg::OP_XOR;
            is_binary = 1'b1;
         end
         bie_pkg::CH_O: begin
            op = bie_pkg::OP_OR;
            is_binary = 1'b1;
         end
         default: ;
      endcase
      // A binary operator first pops everything that binds at least as tightly.
      if (is_binary) begin
         while (op_depth > 0 && !eval_error &&
                binding_strength(op) <= binding_strength(op_store[op_depth-1])) begin
            op_depth--;
            apply_operator(op_store[op_depth]);
         end
         if (!eval_error) push_operator(op);
      end
   endfunction

   function automatic void clear_evaluator();
      op_depth = 0;
      val_depth = 0;
      eval_error = 1'b0;
   endfunction

   // Advance the shadow state by one accepted character.
   function automatic void predict_character(bie_pkg::req_type item);
      bie_pkg::op_type  op;
      bie_pkg::rsp_type outcome;
      if (!eval_error) take_char(item.ch);
      if (item.last) begin
         while (!eval_error && op_depth > 0) begin
            op_depth--;
            op = op_store[op_depth];
            if (op == bie_pkg::OP_LPAR) begin
               eval_error = 1'b1;
            end else begin
               apply_operator(op);
            end
         end
         outcome = '0;
         if (!eval_error && val_depth > 0) begin
            outcome.valid_res = 1'b1;
            outcome.value = val_store[val_depth-1];
         end
         expected_results.push_back(outcome);
         clear_evaluator();
      end
   endfunction

   // Predict on every input transaction and compare on every result transaction.
   always @(posedge clock) begin
      if (reset) begin
         clear_evaluator();
         expected_results.delete();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_character(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected result: valid_res=%0b value=%0b",
                           rsp_data.valid_res, rsp_data.value);
               end
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_data.valid_res !== oldest.valid_res ||
                   rsp_data.value !== oldest.value) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Result mismatch: valid_res exp %0b got %0b, value exp %0b got %0b",
                              oldest.valid_res, rsp_data.valid_res,
                              oldest.value, rsp_data.value);
                  end
               end
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

/* dv/tb_top.sv */
// Top of the evaluator testbench: clock, reset, character stimulus and verdict.
// Depends on bie_pkg, boolean_infix_expression_evaluator and expression_result_checker.
module tb_top;

   localparam int unsigned DEPTH        = bie_pkg::STACK_DEPTH_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 1100;
   localparam int unsigned LIMIT_CYCLES = 1000000;
   localparam int unsigned DRAIN_CYCLES = 400;
   localparam int unsigned LONG_HOLD    = 300;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bie_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bie_pkg::rsp_type rsp_data;
   int unsigned      mismatch_count;
   int unsigned      pending_count;

   int unsigned cycle_count;
   int unsigned sender_burst = 0;
   int unsigned receiver_burst = 0;
   int unsigned results_taken;
   int unsigned hold;
   int unsigned random_items;
   int unsigned kind;
   int unsigned n;
   logic [7:0]  filler;
   logic [7:0]  expr_chars[$];

   always #1 clock = ~clock;

   boolean_infix_expression_evaluator #(.STACK_DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   expression_result_checker #(.STACK_DEPTH(DEPTH)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Idle cycles before a transaction, with occasional stretches of none.
   function automatic int unsigned draw_gap(inout int unsigned burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   // True for bytes the evaluator acts on, in either case.
   function automatic logic is_token(logic [7:0] b);
      logic [7:0] u;
      u = (b >= bie_pkg::CH_LOWER_A && b <= bie_pkg::CH_LOWER_Z) ?
          b - bie_pkg::CASE_SHIFT : b;
      case (u)
         bie_pkg::CH_T, bie_pkg::CH_F, bie_pkg::CH_N, bie_pkg::CH_A,
         bie_pkg::CH_X, bie_pkg::CH_O, bie_pkg::CH_LPAR, bie_pkg::CH_RPAR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] pick_binary();
      case ($urandom_range(0, 2))
         0:       return bie_pkg::CH_A;
         1:       return bie_pkg::CH_X;
         default: return bie_pkg::CH_O;
      endcase
   endfunction

   // Append a character in random case, sometimes preceded by a skipped byte.
   function automatic void emit(logic [7:0] c);
      logic [7:0] noise;
      if ($urandom_range(0, 6) == 0) begin
         noise = 8'($urandom_range(0, 255));
         if (is_token(noise)) noise = bie_pkg::CH_SPACE;
         expr_chars.push_back(noise);
      end
      if (c != bie_pkg::CH_LPAR && c != bie_pkg::CH_RPAR && $urandom_range(0, 1)) begin
         c = c + bie_pkg::CASE_SHIFT;
      end
      expr_chars.push_back(c);
   endfunction

   // Well-formed expression of bounded nesting depth.
   function automatic void build_expression(int unsigned depth);
      int unsigned pick;
      pick = (depth == 0) ? $urandom_range(0, 3) : $urandom_range(0, 9);
      if (pick <= 3) begin
         emit($urandom_range(0, 1) ? bie_pkg::CH_T : bie_pkg::CH_F);
      end else if (pick <= 5) begin
         emit(bie_pkg::CH_N);
         build_expression(depth - 1);
      end else if (pick <= 8) begin
         build_expression(depth - 1);
         emit(pick_binary());
         build_expression(depth - 1);
      end else begin
         emit(bie_pkg::CH_LPAR);
         build_expression(depth - 1);
         emit(bie_pkg::CH_RPAR);
      end
   endfunction

   // Offer one character and wait until the transaction is accepted.
   task automatic send_char(logic [7:0] c, logic is_last);
      bie_pkg::req_type item;
      int unsigned      gap;
      gap = draw_gap(sender_burst);
      item.ch = c;
      item.last = is_last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Send the collected characters as one expression, the final one marked last.
   task automatic send_expression();
      int unsigned i;
      for (i = 0; i < expr_chars.size(); i++) begin
         send_char(expr_chars[i], i == expr_chars.size() - 1);
      end
      expr_chars.delete();
   endtask

   task automatic send_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
      send_expression();
   endtask

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Result receiver: short random stalls, and twice a long hold-off so that
   // the block fills up and stalls its input.
   initial begin
      results_taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (results_taken == 12 || results_taken == 60) begin
            hold = LONG_HOLD;
         end else begin
            hold = draw_gap(receiver_burst);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         results_taken++;
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed expressions: constants, case folding, precedence and every operator.
      send_text("T");
      send_text("nf");
      send_text("TaFoT");
      send_text("(TxF)AnT");
      // Underflow: the flush applies a binary operator with only one value stacked.
      send_text("AT");
      // Unmatched closing and opening brackets.
      send_text("T)");
      send_text("(F");
      // Empty expression and extra values left after the flush.
      send_text(" ");
      send_text("TF");
      // Extreme byte values are skipped.
      expr_chars.push_back(8'h00);
      expr_chars.push_back(8'hff);
      expr_chars.push_back(bie_pkg::CH_T);
      send_expression();

      // Random expressions, mostly well formed.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            build_expression($urandom_range(0, 4));
         end else if (kind < 80) begin
            // Token soup of random length.
            n = $urandom_range(1, 10);
            repeat (n) begin
               case ($urandom_range(0, 9))
                  0:       emit(bie_pkg::CH_T);
                  1:       emit(bie_pkg::CH_F);
                  2:       emit(bie_pkg::CH_N);
                  3:       emit(bie_pkg::CH_A);
                  4:       emit(bie_pkg::CH_X);
                  5:       emit(bie_pkg::CH_O);
                  6:       emit(bie_pkg::CH_LPAR);
                  7:       emit(bie_pkg::CH_RPAR);
                  8:       expr_chars.push_back(bie_pkg::CH_SPACE);
                  default: expr_chars.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end else if (kind < 88) begin
            // A well-formed expression with one character dropped or one stray added.
            build_expression($urandom_range(1, 3));
            if (expr_chars.size() > 1 && $urandom_range(0, 1)) begin
               expr_chars.delete($urandom_range(0, expr_chars.size() - 1));
            end else begin
               case ($urandom_range(0, 3))
                  0:       filler = bie_pkg::CH_A;
                  1:       filler = bie_pkg::CH_RPAR;
                  2:       filler = bie_pkg::CH_LPAR;
                  default: filler = bie_pkg::CH_N;
               endcase
               expr_chars.insert($urandom_range(0, expr_chars.size() - 1), filler);
            end
         end else if (kind < 96) begin
            // Deep bracket nesting, up to the stack depth.
            n = $urandom_range(10, DEPTH - 1);
            repeat (n) emit(bie_pkg::CH_LPAR);
            build_expression(2);
            repeat (n) emit(bie_pkg::CH_RPAR);
         end else begin
            // Run of pushes around the stack depth to reach overflow.
            n = $urandom_range(DEPTH - 2, DEPTH + 3);
            case ($urandom_range(0, 2))
               0:       filler = bie_pkg::CH_T;
               1:       filler = bie_pkg::CH_LPAR;
               default: filler = bie_pkg::CH_N;
            endcase
            repeat (n) expr_chars.push_back(filler);
            expr_chars.push_back(bie_pkg::CH_T);
         end
         random_items += (expr_chars.size() > DEPTH) ? DEPTH : expr_chars.size();
         send_expression();
      end
      req_valid <= 1'b0;

      // Wait for every expected result, then watch for strays.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
